### hw/rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, checked out of reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/pdwta_pkg.sv
// shared types and constants of the pd wheel torque allocator
package pdwta_pkg;

  localparam int unsigned InW     = 16;  // input angle and rate width
  localparam int unsigned GainW   = 16;  // gain and coefficient width
  localparam int unsigned LimW    = 15;  // torque limit width
  localparam int unsigned OutW    = 16;  // wheel command width
  localparam int unsigned BodyW   = 18;  // saturated body torque width
  localparam int unsigned NumWheel = 4;
  localparam int unsigned CfgIdxW = 3;

  // register index map
  typedef enum logic [CfgIdxW-1:0] {
    CFG_KP_ROLL      = 3'd0,
    CFG_KP_PITCH     = 3'd1,
    CFG_KD_ROLL      = 3'd2,
    CFG_KD_PITCH     = 3'd3,
    CFG_KD_YAW       = 3'd4,
    CFG_TILT_COEF    = 3'd5,
    CFG_AXIAL_COEF   = 3'd6,
    CFG_TORQUE_LIMIT = 3'd7
  } cfg_reg_e;

  localparam logic [GainW-1:0] KpRollRst    = 16'd478;
  localparam logic [GainW-1:0] KpPitchRst   = 16'd378;
  localparam logic [GainW-1:0] KdRollRst    = 16'd3190;
  localparam logic [GainW-1:0] KdPitchRst   = 16'd2519;
  localparam logic [GainW-1:0] KdYawRst     = 16'd3055;
  localparam logic [GainW-1:0] TiltCoefRst  = 16'd14655;
  localparam logic [GainW-1:0] AxialCoefRst = 16'd13203;
  localparam logic [LimW-1:0]  TorqueLimRst = 15'd1638;

  // tilt sign per wheel, set bit means negative
  localparam logic [NumWheel-1:0] WheelSxNeg = 4'b1100;
  localparam logic [NumWheel-1:0] WheelSyNeg = 4'b0110;

  // register enables of a two-stage section
  typedef struct packed {
    logic s0;
    logic s1;
  } stage_en_t;

  typedef struct packed {
    logic [GainW-1:0] kp_roll;
    logic [GainW-1:0] kp_pitch;
    logic [GainW-1:0] kd_roll;
    logic [GainW-1:0] kd_pitch;
    logic [GainW-1:0] kd_yaw;
  } gain_cfg_t;

  typedef struct packed {
    logic [GainW-1:0] tilt_coef;
    logic [GainW-1:0] axial_coef;
    logic [LimW-1:0]  torque_limit;
  } alloc_cfg_t;

endpackage

### hw/rtl/pdwta_if.sv
// channel interfaces: attitude input, wheel output, register write
interface pdwta_in_if;
  import pdwta_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [InW-1:0]  roll_angle;
  logic signed [InW-1:0]  pitch_angle;
  logic signed [InW-1:0]  roll_rate;
  logic signed [InW-1:0]  pitch_rate;
  logic signed [InW-1:0]  yaw_rate;
  modport source (output valid, roll_angle, pitch_angle, roll_rate, pitch_rate, yaw_rate,
                  input ready);
  modport sink (input valid, roll_angle, pitch_angle, roll_rate, pitch_rate, yaw_rate,
                output ready);
endinterface

interface pdwta_out_if;
  import pdwta_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [OutW-1:0]   wheel_one_torque;
  logic signed [OutW-1:0]   wheel_two_torque;
  logic signed [OutW-1:0]   wheel_three_torque;
  logic signed [OutW-1:0]   wheel_four_torque;
  logic [NumWheel-1:0]      clamp_flags;
  modport source (output valid, wheel_one_torque, wheel_two_torque, wheel_three_torque,
                  wheel_four_torque, clamp_flags, input ready);
  modport sink (input valid, wheel_one_torque, wheel_two_torque, wheel_three_torque,
                wheel_four_torque, clamp_flags, output ready);
endinterface

interface pdwta_cfg_if;
  import pdwta_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [GainW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/pdwta_body_torque.sv
// pd body torque: gain products, then sum, round and saturate
module pdwta_body_torque import pdwta_pkg::*; (
  input  logic                    clk_i,
  input  stage_en_t               en_i,
  input  gain_cfg_t               gain_i,
  input  logic signed [InW-1:0]   roll_angle_i,
  input  logic signed [InW-1:0]   pitch_angle_i,
  input  logic signed [InW-1:0]   roll_rate_i,
  input  logic signed [InW-1:0]   pitch_rate_i,
  input  logic signed [InW-1:0]   yaw_rate_i,
  output logic signed [BodyW-1:0] tx_o,
  output logic signed [BodyW-1:0] ty_o,
  output logic signed [BodyW-1:0] tz_o
);

  localparam int unsigned ProdW = GainW + InW + 1;
  localparam int unsigned SumW  = ProdW + 2;

  localparam logic signed [SumW-1:0] RndHalf = SumW'(512);
  localparam logic signed [SumW-1:0] BodyMax = SumW'(131071);
  localparam logic signed [SumW-1:0] BodyMin = -SumW'(131072);

  // negate the sum of two products, round to q.15 and saturate
  function automatic logic signed [BodyW-1:0] body_round(
    input logic signed [ProdW-1:0] a,
    input logic signed [ProdW-1:0] b
  );
    logic signed [SumW-1:0] t;
    logic signed [SumW-1:0] r;
    t = RndHalf - SumW'(a) - SumW'(b);
    r = t >>> 10;
    if (r > BodyMax) begin
      r = BodyMax;
    end else if (r < BodyMin) begin
      r = BodyMin;
    end
    return r[BodyW-1:0];
  endfunction

  logic signed [ProdW-1:0] p_kpr_d, p_kdr_d, p_kpp_d, p_kdp_d, p_kdy_d;
  logic signed [ProdW-1:0] p_kpr_q, p_kdr_q, p_kpp_q, p_kdp_q, p_kdy_q;
  logic signed [BodyW-1:0] tx_d, ty_d, tz_d;
  logic signed [BodyW-1:0] tx_q, ty_q, tz_q;

  always_comb begin
    p_kpr_d = $signed({1'b0, gain_i.kp_roll})  * roll_angle_i;
    p_kdr_d = $signed({1'b0, gain_i.kd_roll})  * roll_rate_i;
    p_kpp_d = $signed({1'b0, gain_i.kp_pitch}) * pitch_angle_i;
    p_kdp_d = $signed({1'b0, gain_i.kd_pitch}) * pitch_rate_i;
    p_kdy_d = $signed({1'b0, gain_i.kd_yaw})   * yaw_rate_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s0) begin
      p_kpr_q <= p_kpr_d;
      p_kdr_q <= p_kdr_d;
      p_kpp_q <= p_kpp_d;
      p_kdp_q <= p_kdp_d;
      p_kdy_q <= p_kdy_d;
    end
  end

  always_comb begin
    tx_d = body_round(p_kpr_q, p_kdr_q);
    ty_d = body_round(p_kpp_q, p_kdp_q);
    tz_d = body_round(p_kdy_q, '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      tx_q <= tx_d;
      ty_q <= ty_d;
      tz_q <= tz_d;
    end
  end

  assign tx_o = tx_q;
  assign ty_o = ty_q;
  assign tz_o = tz_q;

endmodule

### hw/rtl/pdwta_wheel_alloc.sv
// pyramid allocation: coefficient products, then per-wheel sum, round and clamp
module pdwta_wheel_alloc import pdwta_pkg::*; (
  input  logic                    clk_i,
  input  stage_en_t               en_i,
  input  alloc_cfg_t              cfg_i,
  input  logic signed [BodyW-1:0] tx_i,
  input  logic signed [BodyW-1:0] ty_i,
  input  logic signed [BodyW-1:0] tz_i,
  output logic signed [OutW-1:0]  wheel_o [NumWheel],
  output logic [NumWheel-1:0]     clamp_o
);

  localparam int unsigned ProdW = GainW + BodyW + 1;
  localparam int unsigned AccW  = ProdW + 2;

  localparam logic signed [AccW-1:0] RndHalf = AccW'(16384);

  logic signed [ProdW-1:0] px_d, py_d, pz_d;
  logic signed [ProdW-1:0] px_q, py_q, pz_q;
  logic signed [OutW-1:0]  wheel_d [NumWheel];
  logic signed [OutW-1:0]  wheel_q [NumWheel];
  logic [NumWheel-1:0]     clamp_d, clamp_q;

  always_comb begin
    px_d = $signed({1'b0, cfg_i.tilt_coef})  * tx_i;
    py_d = $signed({1'b0, cfg_i.tilt_coef})  * ty_i;
    pz_d = $signed({1'b0, cfg_i.axial_coef}) * tz_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s0) begin
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
    end
  end

  // command = floor((16384 - acc) / 32768), clamped to +/- limit
  always_comb begin
    logic signed [AccW-1:0] t;
    logic signed [AccW-1:0] c;
    logic signed [AccW-1:0] lim;
    lim = AccW'(cfg_i.torque_limit);
    for (int w = 0; w < NumWheel; w++) begin
      t = RndHalf - AccW'(pz_q);
      t = WheelSxNeg[w] ? t + AccW'(px_q) : t - AccW'(px_q);
      t = WheelSyNeg[w] ? t + AccW'(py_q) : t - AccW'(py_q);
      c = t >>> 15;
      if (c > lim) begin
        wheel_d[w] = lim[OutW-1:0];
        clamp_d[w] = 1'b1;
      end else if (c < -lim) begin
        wheel_d[w] = OutW'(-lim);
        clamp_d[w] = 1'b1;
      end else begin
        wheel_d[w] = c[OutW-1:0];
        clamp_d[w] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      wheel_q <= wheel_d;
      clamp_q <= clamp_d;
    end
  end

  assign wheel_o = wheel_q;
  assign clamp_o = clamp_q;

endmodule

### hw/rtl/pd_attitude_wheel_torque_allocator.sv
// top level of the pd attitude controller with pyramid reaction wheel allocation
//
// Takes roll/pitch angles and three body rates (signed q2.13), forms pd body
// torques (yaw is rate damping only), spreads them over four pyramid-mounted
// wheels and clamps each command to +/- torque_limit with a per-wheel clamp
// flag. One item is accepted per clock while the output is not held back. An
// accepted input passes through the four stages in order: gain multiply, body
// torque sum/round/saturate, coefficient multiply, wheel sum/round/clamp, the
// last one being the output register. A held output stalls only as far
// back as needed: empty stages keep filling, so inputs are taken while a
// result waits.
// Registers are written through the cfg channel (index 0..7 in the order
// kp_roll, kp_pitch, kd_roll, kd_pitch, kd_yaw, tilt_coef, axial_coef,
// torque_limit) and must only be changed while the pipeline is empty.
`include "assert_macros.svh"

module pd_attitude_wheel_torque_allocator import pdwta_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pdwta_in_if.sink    in_i,
  pdwta_out_if.source out_o,
  pdwta_cfg_if.sink   cfg_i
);

  localparam int unsigned NumStage = 4;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  gain_cfg_t  gain_q;
  alloc_cfg_t alloc_q;
  cfg_reg_e   cfg_idx;

  assign cfg_i.ready = 1'b1;
  assign cfg_idx     = cfg_reg_e'(cfg_i.index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q.kp_roll       <= KpRollRst;
      gain_q.kp_pitch      <= KpPitchRst;
      gain_q.kd_roll       <= KdRollRst;
      gain_q.kd_pitch      <= KdPitchRst;
      gain_q.kd_yaw        <= KdYawRst;
      alloc_q.tilt_coef    <= TiltCoefRst;
      alloc_q.axial_coef   <= AxialCoefRst;
      alloc_q.torque_limit <= TorqueLimRst;
    end else if (cfg_i.valid) begin
      case (cfg_idx)
        CFG_KP_ROLL:      gain_q.kp_roll       <= cfg_i.data;
        CFG_KP_PITCH:     gain_q.kp_pitch      <= cfg_i.data;
        CFG_KD_ROLL:      gain_q.kd_roll       <= cfg_i.data;
        CFG_KD_PITCH:     gain_q.kd_pitch      <= cfg_i.data;
        CFG_KD_YAW:       gain_q.kd_yaw        <= cfg_i.data;
        CFG_TILT_COEF:    alloc_q.tilt_coef    <= cfg_i.data;
        CFG_AXIAL_COEF:   alloc_q.axial_coef   <= cfg_i.data;
        CFG_TORQUE_LIMIT: alloc_q.torque_limit <= cfg_i.data[LimW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control: a stage loads when it is empty or its content moves on
  // ---------------------------------------------------------------------------
  logic [NumStage-1:0] valid_q, valid_d;
  logic [NumStage-1:0] en;
  stage_en_t           body_en, alloc_en;

  always_comb begin
    en[NumStage-1] = !valid_q[NumStage-1] || out_o.ready;
    for (int s = NumStage - 2; s >= 0; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
    valid_d = valid_q;
    valid_d[0] = en[0] ? in_i.valid : valid_q[0];
    for (int s = 1; s < NumStage; s++) begin
      if (en[s]) begin
        valid_d[s] = valid_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_i.ready  = en[0];
  assign body_en.s0  = en[0];
  assign body_en.s1  = en[1];
  assign alloc_en.s0 = en[2];
  assign alloc_en.s1 = en[3];

  // ---------------------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------------------
  logic signed [BodyW-1:0] tx, ty, tz;
  logic signed [OutW-1:0]  wheel [NumWheel];
  logic [NumWheel-1:0]     clamp;

  pdwta_body_torque u_body (
    .clk_i         (clk_i),
    .en_i          (body_en),
    .gain_i        (gain_q),
    .roll_angle_i  (in_i.roll_angle),
    .pitch_angle_i (in_i.pitch_angle),
    .roll_rate_i   (in_i.roll_rate),
    .pitch_rate_i  (in_i.pitch_rate),
    .yaw_rate_i    (in_i.yaw_rate),
    .tx_o          (tx),
    .ty_o          (ty),
    .tz_o          (tz)
  );

  pdwta_wheel_alloc u_alloc (
    .clk_i   (clk_i),
    .en_i    (alloc_en),
    .cfg_i   (alloc_q),
    .tx_i    (tx),
    .ty_i    (ty),
    .tz_i    (tz),
    .wheel_o (wheel),
    .clamp_o (clamp)
  );

  assign out_o.valid              = valid_q[NumStage-1];
  assign out_o.wheel_one_torque   = wheel[0];
  assign out_o.wheel_two_torque   = wheel[1];
  assign out_o.wheel_three_torque = wheel[2];
  assign out_o.wheel_four_torque  = wheel[3];
  assign out_o.clamp_flags        = clamp;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  logic signed [OutW-1:0] lim_pos, lim_neg;
  logic                   in_xfer;
  logic                   one_on_lim;
  logic                   three_in_lim;

  assign lim_pos      = OutW'(alloc_q.torque_limit);
  assign lim_neg      = -lim_pos;
  assign in_xfer      = in_i.valid && in_i.ready;
  assign one_on_lim   = (out_o.wheel_one_torque == lim_pos) ||
                        (out_o.wheel_one_torque == lim_neg);
  assign three_in_lim = (out_o.wheel_three_torque <= lim_pos) &&
                        (out_o.wheel_three_torque >= lim_neg);

  // a clamped wheel one sits exactly on the limit
  `ASSERT_IMPL(a_clamp_at_limit, clk_i, rst_ni, out_o.valid && out_o.clamp_flags[0], one_on_lim)
  // an unclamped wheel three stays inside the limit
  `ASSERT_IMPL(a_free_in_range, clk_i, rst_ni, out_o.valid && !out_o.clamp_flags[2], three_in_lim)
  // a taken output frees the whole pipeline for a new transfer
  `ASSERT_IMPL(a_no_stall_when_drained, clk_i, rst_ni, out_o.ready, in_i.ready)
  // an input transfer always lands in the first stage
  `ASSERT_NEXT(a_input_lands, clk_i, rst_ni, in_xfer, valid_q[0])

endmodule

### bench/pd_attitude_wheel_torque_allocator_tb.sv
// self-checking bench for the pd attitude controller and its pyramid wheel allocation
module pd_attitude_wheel_torque_allocator_tb;
  import pdwta_pkg::*;

  localparam int unsigned ClkPeriod     = 20;
  localparam int unsigned TimeoutCycles = 400000;
  // pipeline is four deep; spare settle time before touching registers
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned NumReg        = 1 << CfgIdxW;
  localparam int unsigned IdlePct       = 35;
  localparam longint      BodyMax       = (longint'(1) << (BodyW - 1)) - 1;
  localparam longint      BodyMin       = -(longint'(1) << (BodyW - 1));

  // reset limit, handy for the hand-checked rows of the table
  localparam logic signed [OutW-1:0] RstLim    = signed'(16'(TorqueLimRst));
  localparam logic signed [OutW-1:0] RstLimNeg = -signed'(16'(TorqueLimRst));

  typedef struct packed {
    logic signed [InW-1:0] roll_angle;
    logic signed [InW-1:0] pitch_angle;
    logic signed [InW-1:0] roll_rate;
    logic signed [InW-1:0] pitch_rate;
    logic signed [InW-1:0] yaw_rate;
  } attitude_t;

  typedef struct packed {
    logic signed [OutW-1:0] wheel_one_torque;
    logic signed [OutW-1:0] wheel_two_torque;
    logic signed [OutW-1:0] wheel_three_torque;
    logic signed [OutW-1:0] wheel_four_torque;
    logic [NumWheel-1:0]    clamp_flags;
  } wheel_result_t;

  typedef struct packed {
    attitude_t     att;
    logic          known;  // result typed in below instead of predicted
    wheel_result_t want;
  } steer_row_t;

  typedef logic [GainW-1:0] reg_image_t [NumReg];

  localparam int unsigned SteerRows = 17;

  // directed stimulus, all at the reset register values
  steer_row_t steer_table [SteerRows] = '{
    // all quiet: nothing to do
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'h0}},
    // full roll angle either way drives every wheel into its limit
    '{'{16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{RstLim, RstLim, RstLimNeg, RstLimNeg, 4'hF}},
    '{'{16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{RstLimNeg, RstLimNeg, RstLim, RstLim, 4'hF}},
    // full pitch angle either way
    '{'{16'sd0, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{RstLim, RstLimNeg, RstLimNeg, RstLim, 4'hF}},
    '{'{16'sd0, 16'sh8000, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{RstLimNeg, RstLim, RstLim, RstLimNeg, 4'hF}},
    // full yaw rate pushes all four wheels the same way
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF}, 1'b1,
      '{RstLim, RstLim, RstLim, RstLim, 4'hF}},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh8000}, 1'b1,
      '{RstLimNeg, RstLimNeg, RstLimNeg, RstLimNeg, 4'hF}},
    // rate extremes and mixes go through the predictor
    '{'{16'sd0, 16'sd0, 16'sh7FFF, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sd0}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sd0}, 1'b0, '0},
    '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b0, '0},
    '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0},
    // lsb-sized and small inputs exercise the round-half-up steps
    '{'{16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1}, 1'b0, '0},
    '{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b0, '0},
    '{'{16'sd8192, -16'sd8192, 16'sd100, -16'sd100, 16'sd50}, 1'b0, '0},
    '{'{-16'sd300, 16'sd220, -16'sd40, 16'sd75, -16'sd900}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  // bench copy of the register file, indexed by register name
  logic [GainW-1:0] reg_copy [NumReg];

  // wheel commands predicted for accepted inputs, oldest first
  wheel_result_t pending_wheel_cmds [$];

  int unsigned mismatches = 0;
  bit          quiet_run;  // no idling on either side while set

  pdwta_in_if  in_if ();
  pdwta_out_if out_if ();
  pdwta_cfg_if cfg_if ();

  pd_attitude_wheel_torque_allocator DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // runaway guard
  initial begin
    #(ClkPeriod * TimeoutCycles);
    $display("RESULT: ERROR");
    $finish;
  end

  // rounded and saturated body torque of one axis, q.15 in 18 bits
  function automatic longint body_torque(logic [GainW-1:0] gain_a, logic signed [InW-1:0] in_a,
                                         logic [GainW-1:0] gain_b, logic signed [InW-1:0] in_b);
    longint t;
    t = -(longint'(gain_a) * longint'(in_a) + longint'(gain_b) * longint'(in_b));
    // arithmetic shift on a signed value is the floor, so this rounds half up
    t = (t + 512) >>> 10;
    if (t > BodyMax) begin
      t = BodyMax;
    end else if (t < BodyMin) begin
      t = BodyMin;
    end
    return t;
  endfunction

  // wheel commands and clamp flags for one attitude sample
  function automatic wheel_result_t predict_wheels(attitude_t a);
    longint tx, ty, tz, tilt, axial, lim, acc, c;
    logic signed [OutW-1:0] cmd [NumWheel];
    logic [NumWheel-1:0] flags;
    wheel_result_t r;
    tx = body_torque(reg_copy[CFG_KP_ROLL], a.roll_angle, reg_copy[CFG_KD_ROLL], a.roll_rate);
    ty = body_torque(reg_copy[CFG_KP_PITCH], a.pitch_angle,
                     reg_copy[CFG_KD_PITCH], a.pitch_rate);
    // yaw has rate damping only
    tz = body_torque(reg_copy[CFG_KD_YAW], a.yaw_rate, '0, '0);
    tilt  = longint'(reg_copy[CFG_TILT_COEF]);
    axial = longint'(reg_copy[CFG_AXIAL_COEF]);
    lim   = longint'(reg_copy[CFG_TORQUE_LIMIT]);
    flags = '0;
    for (int w = 0; w < NumWheel; w++) begin
      acc = (WheelSxNeg[w] ? -tilt : tilt) * tx + (WheelSyNeg[w] ? -tilt : tilt) * ty
          + axial * tz;
      // command is the negated projection, rounded half up to q.15
      c = (16384 - acc) >>> 15;
      if (c > lim) begin
        c = lim;
        flags[w] = 1'b1;
      end else if (c < -lim) begin
        c = -lim;
        flags[w] = 1'b1;
      end
      cmd[w] = c[OutW-1:0];
    end
    r.wheel_one_torque   = cmd[0];
    r.wheel_two_torque   = cmd[1];
    r.wheel_three_torque = cmd[2];
    r.wheel_four_torque  = cmd[3];
    r.clamp_flags        = flags;
    return r;
  endfunction

  function automatic void compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // mix of full-range, small and extreme values per field
  function automatic logic signed [InW-1:0] random_field();
    logic signed [InW-1:0] v;
    case ($urandom_range(0, 3))
      0, 1: v = InW'($urandom);
      2: v = InW'($urandom_range(0, 2047)) - 16'sd1024;
      default: begin
        case ($urandom_range(0, 3))
          0: v = 16'sh7FFF;
          1: v = 16'sh8000;
          2: v = '0;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic attitude_t random_attitude();
    attitude_t a;
    a.roll_angle  = random_field();
    a.pitch_angle = random_field();
    a.roll_rate   = random_field();
    a.pitch_rate  = random_field();
    a.yaw_rate    = random_field();
    return a;
  endfunction

  // gains mostly moderate so that not every command ends up clamped
  function automatic reg_image_t random_image();
    reg_image_t img;
    for (int i = 0; i < NumReg; i++) begin
      case (cfg_reg_e'(i))
        CFG_TILT_COEF, CFG_AXIAL_COEF: img[i] = GainW'($urandom);
        CFG_TORQUE_LIMIT: begin
          img[i] = ($urandom_range(0, 1) != 0) ? GainW'($urandom_range(0, 4095))
                                               : GainW'($urandom);
        end
        default: begin
          img[i] = ($urandom_range(0, 3) == 0) ? GainW'($urandom)
                                               : GainW'($urandom_range(0, 8191));
        end
      endcase
    end
    return img;
  endfunction

  // writes all registers back to back; valid stays high across the burst
  task automatic program_regs(input reg_image_t img);
    for (int i = 0; i < NumReg; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= cfg_reg_e'(i);
      cfg_if.data  <= img[i];
      do @(posedge clk); while (!cfg_if.ready);
      // bits above the limit width are dropped
      reg_copy[i] = (cfg_reg_e'(i) == CFG_TORQUE_LIMIT) ? GainW'(img[i][LimW-1:0]) : img[i];
    end
    cfg_if.valid <= 1'b0;
  endtask

  // one input transfer, with an optional random gap ahead of it
  task automatic send_attitude(input attitude_t a, input logic known, input wheel_result_t want);
    if (!quiet_run && $urandom_range(99) < IdlePct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.roll_angle  <= a.roll_angle;
    in_if.pitch_angle <= a.pitch_angle;
    in_if.roll_rate   <= a.roll_rate;
    in_if.pitch_rate  <= a.pitch_rate;
    in_if.yaw_rate    <= a.yaw_rate;
    do @(posedge clk); while (!in_if.ready);
    pending_wheel_cmds.push_back(known ? want : predict_wheels(a));
  endtask

  task automatic run_random(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      send_attitude(random_attitude(), 1'b0, '0);
    end
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain_pipeline();
    in_if.valid <= 1'b0;
    while (pending_wheel_cmds.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // result side: random back-pressure, none during the quiet stretch
  always @(posedge clk) begin
    out_if.ready <= quiet_run || ($urandom_range(99) >= IdlePct);
  end

  // result checking at every output transfer
  always @(posedge clk) begin
    wheel_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_wheel_cmds.size() == 0) begin
        $error("wheel command transfer with no pending prediction");
        mismatches++;
      end else begin
        want = pending_wheel_cmds.pop_front();
        compare_field("wheel_one_torque", want.wheel_one_torque, out_if.wheel_one_torque);
        compare_field("wheel_two_torque", want.wheel_two_torque, out_if.wheel_two_torque);
        compare_field("wheel_three_torque", want.wheel_three_torque,
                      out_if.wheel_three_torque);
        compare_field("wheel_four_torque", want.wheel_four_torque, out_if.wheel_four_torque);
        compare_field("clamp_flags", want.clamp_flags, out_if.clamp_flags);
      end
    end
  end

  initial begin
    reg_image_t img;
    rst_n        = 1'b0;
    quiet_run    = 1'b0;
    in_if.valid       = 1'b0;
    in_if.roll_angle  = '0;
    in_if.pitch_angle = '0;
    in_if.roll_rate   = '0;
    in_if.pitch_rate  = '0;
    in_if.yaw_rate    = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_KP_ROLL;
    cfg_if.data  = '0;
    reg_copy[CFG_KP_ROLL]      = KpRollRst;
    reg_copy[CFG_KP_PITCH]     = KpPitchRst;
    reg_copy[CFG_KD_ROLL]      = KdRollRst;
    reg_copy[CFG_KD_PITCH]     = KdPitchRst;
    reg_copy[CFG_KD_YAW]       = KdYawRst;
    reg_copy[CFG_TILT_COEF]    = TiltCoefRst;
    reg_copy[CFG_AXIAL_COEF]   = AxialCoefRst;
    reg_copy[CFG_TORQUE_LIMIT] = GainW'(TorqueLimRst);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // reset register values: directed rows, then random samples
    for (int i = 0; i < SteerRows; i++) begin
      send_attitude(steer_table[i].att, steer_table[i].known, steer_table[i].want);
    end
    run_random(240);
    drain_pipeline();

    // every register at full scale, limit write carries a bit above its width;
    // this phase also runs with no idling on either side
    quiet_run = 1'b1;
    for (int i = 0; i < NumReg; i++) img[i] = '1;
    program_regs(img);
    run_random(200);
    drain_pipeline();
    quiet_run = 1'b0;

    // reset gains with a zero limit: any nonzero command clamps to zero
    img = reg_copy;
    img[CFG_KP_ROLL]      = KpRollRst;
    img[CFG_KP_PITCH]     = KpPitchRst;
    img[CFG_KD_ROLL]      = KdRollRst;
    img[CFG_KD_PITCH]     = KdPitchRst;
    img[CFG_KD_YAW]       = KdYawRst;
    img[CFG_TILT_COEF]    = TiltCoefRst;
    img[CFG_AXIAL_COEF]   = AxialCoefRst;
    img[CFG_TORQUE_LIMIT] = '0;
    program_regs(img);
    run_random(150);
    drain_pipeline();

    // zero gains with full coefficients
    img[CFG_KP_ROLL]      = '0;
    img[CFG_KP_PITCH]     = '0;
    img[CFG_KD_ROLL]      = '0;
    img[CFG_KD_PITCH]     = '0;
    img[CFG_KD_YAW]       = '0;
    img[CFG_TILT_COEF]    = '1;
    img[CFG_AXIAL_COEF]   = '1;
    img[CFG_TORQUE_LIMIT] = GainW'(1000);
    program_regs(img);
    run_random(100);
    drain_pipeline();

    // reset gains with zero coefficients, widest limit
    img[CFG_KP_ROLL]      = KpRollRst;
    img[CFG_KP_PITCH]     = KpPitchRst;
    img[CFG_KD_ROLL]      = KdRollRst;
    img[CFG_KD_PITCH]     = KdPitchRst;
    img[CFG_KD_YAW]       = KdYawRst;
    img[CFG_TILT_COEF]    = '0;
    img[CFG_AXIAL_COEF]   = '0;
    img[CFG_TORQUE_LIMIT] = GainW'(16'h7FFF);
    program_regs(img);
    run_random(100);
    drain_pipeline();

    // random register settings
    for (int p = 0; p < 4; p++) begin
      program_regs(random_image());
      run_random(140);
      drain_pipeline();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
